/* hdl/des_block_decrypt_unit_defines.svh */
// Assertion macros for the DES decrypt pipeline
`ifndef DES_BLOCK_DECRYPT_UNIT_DEFINES_SVH
`define DES_BLOCK_DECRYPT_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DES_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define DES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DES_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define DES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hdl/desd_pkg.sv */
package desd_pkg;

  localparam int Rounds = 16;
  localparam int HalfBits = 28;

  typedef logic [63:0] blk_t;
  typedef logic [HalfBits-1:0] half_t;
  typedef logic [47:0] sub_t;

  // per-round data carried down the pipe
  typedef struct packed {
    logic  vld;
    logic [31:0] l;
    logic [31:0] r;
    half_t c;
    half_t d;
  } stage_t;

  localparam logic [7:0] TabIp [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam logic [7:0] TabFp [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam logic [7:0] TabE [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam logic [7:0] TabP [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};
  localparam logic [7:0] TabPc1 [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
    63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
  localparam logic [7:0] TabPc2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
  localparam logic [3:0] TabS [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
      0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
      15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
      3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
      13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
      13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
      1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
      13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
      3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
      14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
      11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
      10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
      4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
      13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,9,5,0,2,
      6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
      1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
      2,1,14,7,4,10,8,13,15,12,9,0,5,6,11,3}};

  // DES tables number bits from the MSB, starting at 1
  function automatic blk_t perm_ip(blk_t x);
    blk_t y;
    for (int i = 0; i < 64; i++) y[63-i] = x[64 - int'(TabIp[i])];
    return y;
  endfunction

  function automatic blk_t perm_fp(blk_t x);
    blk_t y;
    for (int i = 0; i < 64; i++) y[63-i] = x[64 - int'(TabFp[i])];
    return y;
  endfunction

  function automatic logic [55:0] perm_pc1(blk_t x);
    logic [55:0] y;
    for (int i = 0; i < 56; i++) y[55-i] = x[64 - int'(TabPc1[i])];
    return y;
  endfunction

  function automatic sub_t perm_pc2(logic [55:0] x);
    sub_t y;
    for (int i = 0; i < 48; i++) y[47-i] = x[56 - int'(TabPc2[i])];
    return y;
  endfunction

  function automatic half_t rotr(half_t x, int unsigned sh);
    half_t y;
    unique case (sh)
      0: y = x;
      1: y = {x[0], x[27:1]};
      default: y = {x[1:0], x[27:2]};
    endcase
    return y;
  endfunction

  function automatic int unsigned round_shift(int unsigned rnd);
    int unsigned s;
    if (rnd == 0) s = 0;
    else if (rnd == 1 || rnd == 8 || rnd == 15) s = 1;
    else s = 2;
    return s;
  endfunction

  function automatic logic [31:0] feistel(logic [31:0] r, sub_t k);
    sub_t x;
    logic [31:0] s;
    logic [31:0] y;
    logic [5:0] six;
    for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(TabE[i])];
    x = x ^ k;
    for (int i = 0; i < 8; i++) begin
      six = x[47-6*i -: 6];
      s[31-4*i -: 4] = TabS[i][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) y[31-i] = s[32 - int'(TabP[i])];
    return y;
  endfunction

endpackage

/* hdl/desd_if.sv */
interface desd_if;
  logic valid;
  logic ready;
  logic [63:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/desd_round.sv */
// One Feistel round with its key rotation, registered on advance.
module desd_round import desd_pkg::*; #() (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic [3:0] rnd,
  input  stage_t d_in,
  output stage_t d_out
);
  stage_t q_r, q_nxt;
  half_t c, d;

  always_comb begin
    c = rotr(d_in.c, round_shift(32'(rnd)));
    d = rotr(d_in.d, round_shift(32'(rnd)));
    q_nxt.vld = d_in.vld;
    q_nxt.c = c;
    q_nxt.d = d;
    q_nxt.l = d_in.r;
    q_nxt.r = d_in.l ^ feistel(d_in.r, perm_pc2({c, d}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else if (adv) begin
      q_r.vld <= q_nxt.vld;
    end
    if (adv) begin
      q_r.l <= q_nxt.l;
      q_r.r <= q_nxt.r;
      q_r.c <= q_nxt.c;
      q_r.d <= q_nxt.d;
    end
  end

  assign d_out = q_r;
endmodule

/* hdl/des_block_decrypt_unit.sv */
// DES decryption, 16-round unrolled pipeline.
// Stages from input accept to output valid: IP/PC-1 stage, 16 round stages,
// FP output register. Throughput: one word per cycle unless the output stalls.
// Pipeline advances as one unit whenever the output register is free or taken.
// Reset (rst_n synchronous, low) clears all valid bits and the key to zero.
`include "des_block_decrypt_unit_defines.svh"
module des_block_decrypt_unit import desd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [63:0] cfg_wdata,
  desd_if.sink in_ch,
  desd_if.source out_ch
);
  blk_t key_r;
  stage_t st [Rounds+1];
  stage_t s0_r;
  logic out_vld_r;
  blk_t out_data_r;
  logic adv;
  blk_t ip;
  logic [55:0] k56;

  // stall everything only when the output word is held
  assign adv = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) key_r <= '0;
    else if (cfg_we) key_r <= cfg_wdata;
  end

  always_comb begin
    ip = perm_ip(in_ch.data);
    k56 = perm_pc1(key_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.vld <= 1'b0;
    end else if (adv) begin
      s0_r.vld <= in_ch.valid;
    end
    if (adv) begin
      s0_r.l <= ip[63:32];
      s0_r.r <= ip[31:0];
      s0_r.c <= k56[55:28];
      s0_r.d <= k56[27:0];
    end
  end

  assign st[0] = s0_r;

  for (genvar g = 0; g < Rounds; g++) begin : g_rnd
    desd_round u_round (
      .clk  (clk),
      .rst_n(rst_n),
      .adv  (adv),
      .rnd  (4'(g)),
      .d_in (st[g]),
      .d_out(st[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= st[Rounds].vld;
    end
    if (adv) out_data_r <= perm_fp({st[Rounds].r, st[Rounds].l});
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data = out_data_r;

  `DES_ASSERT_NEXT(a_hold, clk, rst_n, out_vld_r && !out_ch.ready, out_vld_r && $stable(out_data_r), "output word dropped under stall")
  `DES_ASSERT_IMPL(a_rdy, clk, rst_n, out_vld_r && !out_ch.ready, !in_ch.ready, "input taken while pipe stalled")
  `DES_ASSERT_NEXT(a_flow, clk, rst_n, adv && st[Rounds].vld, out_vld_r, "round output lost")
endmodule

/* verif/testbench.sv */
module testbench;
  import desd_pkg::*;

  // Expected plaintext words and the key that decrypts them
  class plain_scoreboard;
    blk_t key;
    blk_t plain_q[$];
    int errors;
    int checked;

    function new();
      key = '0;
      errors = 0;
      checked = 0;
    endfunction

    function blk_t decrypt(blk_t k, blk_t ct);
      logic [55:0] k56;
      logic [55:0] cd;
      half_t c;
      half_t d;
      blk_t b;
      blk_t pt;
      logic [31:0] l;
      logic [31:0] r;
      logic [31:0] t;
      logic [31:0] sbox_out;
      logic [31:0] f;
      sub_t sk;
      sub_t ex;
      logic [5:0] six;
      int sh;
      for (int i = 0; i < 56; i++) k56[55-i] = k[64 - int'(TabPc1[i])];
      c = k56[55:28];
      d = k56[27:0];
      for (int i = 0; i < 64; i++) b[63-i] = ct[64 - int'(TabIp[i])];
      l = b[63:32];
      r = b[31:0];
      for (int rnd = 1; rnd <= Rounds; rnd++) begin
        // decryption schedule walks the subkeys backwards
        if (rnd == 1) sh = 0;
        else if (rnd == 2 || rnd == 9 || rnd == 16) sh = 1;
        else sh = 2;
        repeat (sh) begin
          c = {c[0], c[27:1]};
          d = {d[0], d[27:1]};
        end
        cd = {c, d};
        for (int i = 0; i < 48; i++) sk[47-i] = cd[56 - int'(TabPc2[i])];
        for (int i = 0; i < 48; i++) ex[47-i] = r[32 - int'(TabE[i])];
        ex = ex ^ sk;
        for (int j = 0; j < 8; j++) begin
          six = ex[47-6*j -: 6];
          sbox_out[31-4*j -: 4] = TabS[j][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) f[31-i] = sbox_out[32 - int'(TabP[i])];
        t = r;
        r = l ^ f;
        l = t;
      end
      b = {r, l};
      for (int i = 0; i < 64; i++) pt[63-i] = b[64 - int'(TabFp[i])];
      return pt;
    endfunction

    function void note_cipher(blk_t ct);
      plain_q.push_back(decrypt(key, ct));
    endfunction

    function void check_plain(blk_t got);
      blk_t want;
      if (plain_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        errors++;
      end else begin
        want = plain_q.pop_front();
        checked++;
        if (got !== want) begin
          $display("%0t: plain_block mismatch: expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  localparam int CycleLimit = 200000;
  localparam int Drain = 24;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [63:0] cfg_wdata;
  int send_idle;
  int recv_idle;
  int hold_req;
  int hold_cnt;
  int cycles;
  int sent;
  plain_scoreboard sb;

  desd_if in_ch();
  desd_if out_ch();

  des_block_decrypt_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    hold_req = 0;
    hold_cnt = 0;
    cycles = 0;
    sent = 0;
    sb = new();
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_cipher(in_ch.data);
      if (out_ch.valid && out_ch.ready) sb.check_plain(out_ch.data);
    end
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, sb.plain_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_word(blk_t ct);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= ct;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    in_ch.valid <= 1'b0;
    while (sb.plain_q.size() != 0) @(negedge clk);
    repeat (Drain) @(negedge clk);
  endtask

  task automatic load_key(blk_t k);
    drain_pipe();
    cfg_we <= 1'b1;
    cfg_wdata <= k;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.key = k;
  endtask

  task automatic random_words(int n);
    repeat (n) send_word({$urandom, $urandom});
  endtask

  blk_t k_rand;

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // key after reset is zero
    send_word('0);
    send_word('1);
    send_word(64'h0123456789ABCDEF);

    // textbook vector plus field extremes and single bits
    load_key(64'h133457799BBCDFF1);
    send_word(64'h85E813540F0AB405);
    send_word('0);
    send_word('1);
    send_word(64'hAAAAAAAAAAAAAAAA);
    send_word(64'h5555555555555555);
    send_word(64'h8000000000000000);
    send_word(64'h0000000000000001);
    send_word(64'h00000000FFFFFFFF);
    send_word(64'hFFFFFFFF00000000);

    // all-ones key, then the same key with parity bits cleared
    load_key('1);
    send_word(64'h0123456789ABCDEF);
    send_word('0);
    load_key(64'hFEFEFEFEFEFEFEFE);
    send_word(64'h0123456789ABCDEF);
    send_word('0);
    // weak key
    load_key(64'h0101010101010101);
    send_word(64'h95F8A5E5DD31D900);
    send_word('1);

    k_rand = {$urandom, $urandom};
    load_key(k_rand);
    send_idle = 38;
    recv_idle = 86;
    random_words(150);

    load_key(k_rand ^ 64'h0101010101010101);
    send_idle = 86;
    recv_idle = 38;
    random_words(150);

    load_key({$urandom, $urandom});
    send_idle = 0;
    recv_idle = 0;
    hold_req = 150;
    random_words(150);

    load_key('0);
    random_words(50);

    drain_pipe();
    $display("%0d ciphertext words sent, %0d plaintext words checked", sent, sb.checked);
    $display("keys: reset, textbook, all ones, parity variants, weak, random; stalls both sides");
    if (sb.errors == 0 && sb.plain_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* des_block_decrypt_unit.f */
+incdir+hdl
hdl/desd_pkg.sv
hdl/desd_if.sv
hdl/desd_round.sv
hdl/des_block_decrypt_unit.sv
verif/testbench.sv
